// ===== rtl/bqpp_pkg.sv =====
package bqpp_pkg;

	localparam int WINDOW_DEPTH_DEF = 128;
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic signed [31:0] LEVEL_GAIN_RST = 32'sd575418;
	localparam logic signed [31:0] LEVEL_FB1_RST = -32'sd1022890485;
	localparam logic signed [31:0] LEVEL_FB2_RST = 32'sd488321676;
	localparam logic signed [31:0] RESP_GAIN_RST = 32'sd18024367;
	localparam logic signed [31:0] RESP_FB1_RST = -32'sd761803718;
	localparam logic signed [31:0] RESP_FB2_RST = 32'sd297029201;
	localparam logic [7:0] WINDOW_LEN_RST = 8'd75;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_LEVEL_GAIN = 3'd0,
		REG_LEVEL_FB1 = 3'd1,
		REG_LEVEL_FB2 = 3'd2,
		REG_RESP_GAIN = 3'd3,
		REG_RESP_FB1 = 3'd4,
		REG_RESP_FB2 = 3'd5,
		REG_WINDOW_LEN = 3'd6
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_B,
		ST_RND_P,
		ST_SUM_Y,
		ST_MUL_A1,
		ST_MUL_A2,
		ST_RND_Q2,
		ST_UPDATE,
		ST_WRITE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load_in;
		logic mul_b;
		logic rnd_p;
		logic sum_y;
		logic mul_a1;
		logic mul_a2;
		logic rnd_q2;
		logic update;
		logic win_write;
		logic scan_rd;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic resp;
		logic cnt_zero;
		logic cnt_one;
		logic out_free;
	} stat_t;

	// Round half up by 2^-29: floor((v + 2^28) / 2^29).
	function automatic logic signed [34:0] rnd29(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + 64'sd268435456;
		return t[63:29];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
		logic signed [31:0] r;
		if (v > 50'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -50'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
		logic signed [47:0] r;
		if (v > 50'sd140737488355327) begin
			r = 48'sh7fffffffffff;
		end else if (v < -50'sd140737488355328) begin
			r = 48'sh800000000000;
		end else begin
			r = v[47:0];
		end
		return r;
	endfunction

endpackage

// ===== rtl/bqpp_ram.sv =====
module bqpp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/bqpp_ctrl.sv =====
module bqpp_ctrl import bqpp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  s_tvalid,
	output logic  s_tready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_MUL_B;
				end
			end
			ST_MUL_B:  state_d = ST_RND_P;
			ST_RND_P:  state_d = ST_SUM_Y;
			ST_SUM_Y:  state_d = ST_MUL_A1;
			ST_MUL_A1: state_d = ST_MUL_A2;
			ST_MUL_A2: state_d = ST_RND_Q2;
			ST_RND_Q2: state_d = ST_UPDATE;
			ST_UPDATE: state_d = stat.resp ? ST_WRITE : ST_FIN;
			ST_WRITE:  state_d = ST_SCAN;
			ST_SCAN: begin
				if (stat.cnt_zero) begin
					state_d = ST_FIN;
				end else if (stat.cnt_one) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_FIN;
			ST_FIN: begin
				if (stat.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load_in = s_tvalid;
			end
			ST_MUL_B:  cmd.mul_b = 1'b1;
			ST_RND_P:  cmd.rnd_p = 1'b1;
			ST_SUM_Y:  cmd.sum_y = 1'b1;
			ST_MUL_A1: cmd.mul_a1 = 1'b1;
			ST_MUL_A2: cmd.mul_a2 = 1'b1;
			ST_RND_Q2: cmd.rnd_q2 = 1'b1;
			ST_UPDATE: cmd.update = 1'b1;
			ST_WRITE:  cmd.win_write = 1'b1;
			ST_SCAN:   cmd.scan_rd = !stat.cnt_zero;
			ST_FIN:    cmd.load_out = stat.out_free;
			default: ;
		endcase
	end

endmodule

// ===== rtl/bqpp_dp.sv =====
module bqpp_dp import bqpp_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [31:0]           s_tdata,
	input  logic [0:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [63:0]           m_tdata,
	output logic [0:0]            m_tuser,
	input  cmd_t                  cmd,
	output stat_t                 stat
);

	localparam int AW = $clog2(WINDOW_DEPTH);
	localparam int FW = $clog2(WINDOW_DEPTH + 1);

	logic signed [31:0] level_gain_q, level_fb1_q, level_fb2_q;
	logic signed [31:0] resp_gain_q, resp_fb1_q, resp_fb2_q;
	logic [7:0]         window_len_q;

	logic signed [47:0] lvl_d1_q, lvl_d2_q, rsp_d1_q, rsp_d2_q;
	logic [AW-1:0]      wp_q;
	logic [FW-1:0]      fill_q;
	logic [31:0]        last_spread_q;

	logic               op_q;
	logic signed [31:0] x_q;
	logic signed [63:0] prod_q;
	logic signed [34:0] p0_q, q1_q, q2_q;
	logic signed [31:0] y_q;

	logic [AW-1:0]      rd_ptr_q;
	logic [FW-1:0]      cnt_q;
	logic               rdv_q;
	logic signed [31:0] mn_q, mx_q;

	logic               out_valid_q;
	logic               out_channel_q;
	logic [31:0]        out_filt_q;
	logic [31:0]        out_peak_q;

	logic signed [31:0] b0_sel, a1_sel, a2_sel;
	logic signed [47:0] d1_sel, d2_sel;
	logic signed [31:0] mul_a, mul_b;
	logic signed [49:0] d1_sum, d2_sum;
	logic signed [47:0] d1_new, d2_new;
	logic [FW-1:0]      len_eff;
	logic [FW:0]        fill_inc;
	logic [FW-1:0]      fill_new;
	logic [AW-1:0]      wp_dec;
	logic [AW-1:0]      rd_dec;
	logic [AW-1:0]      wp_inc;
	logic [31:0]        ram_rdata;
	logic signed [31:0] rd_val;
	logic [32:0]        spread;
	logic [31:0]        peak_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_gain_q <= LEVEL_GAIN_RST;
			level_fb1_q <= LEVEL_FB1_RST;
			level_fb2_q <= LEVEL_FB2_RST;
			resp_gain_q <= RESP_GAIN_RST;
			resp_fb1_q <= RESP_FB1_RST;
			resp_fb2_q <= RESP_FB2_RST;
			window_len_q <= WINDOW_LEN_RST;
		end else if (cfg_wr_en) begin
			case (reg_index_t'(cfg_index))
				REG_LEVEL_GAIN: level_gain_q <= cfg_data;
				REG_LEVEL_FB1:  level_fb1_q <= cfg_data;
				REG_LEVEL_FB2:  level_fb2_q <= cfg_data;
				REG_RESP_GAIN:  resp_gain_q <= cfg_data;
				REG_RESP_FB1:   resp_fb1_q <= cfg_data;
				REG_RESP_FB2:   resp_fb2_q <= cfg_data;
				REG_WINDOW_LEN: window_len_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign b0_sel = op_q ? resp_gain_q : level_gain_q;
	assign a1_sel = op_q ? resp_fb1_q : level_fb1_q;
	assign a2_sel = op_q ? resp_fb2_q : level_fb2_q;
	assign d1_sel = op_q ? rsp_d1_q : lvl_d1_q;
	assign d2_sel = op_q ? rsp_d2_q : lvl_d2_q;

	always_comb begin
		mul_a = y_q;
		mul_b = a2_sel;
		if (cmd.mul_b) begin
			mul_a = x_q;
			mul_b = b0_sel;
		end else if (cmd.mul_a1) begin
			mul_b = a1_sel;
		end
	end

	assign d1_sum = (50'(p0_q) <<< 1) - 50'(q1_q) + 50'(d2_sel);
	assign d2_sum = 50'(p0_q) - 50'(q2_q);
	assign d1_new = sat48(d1_sum);
	assign d2_new = sat48(d2_sum);

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q <= s_tuser[0];
			x_q <= s_tdata;
		end
		if (cmd.mul_b || cmd.mul_a1 || cmd.mul_a2) begin
			prod_q <= mul_a * mul_b;
		end
		if (cmd.rnd_p) begin
			p0_q <= rnd29(prod_q);
		end
		if (cmd.sum_y) begin
			y_q <= sat32(50'(p0_q) + 50'(d1_sel));
		end
		if (cmd.mul_a2) begin
			q1_q <= rnd29(prod_q);
		end
		if (cmd.rnd_q2) begin
			q2_q <= rnd29(prod_q);
		end
	end

	always_comb begin
		if (window_len_q == 8'd0) begin
			len_eff = FW'(1);
		end else if (32'(window_len_q) > 32'(WINDOW_DEPTH)) begin
			len_eff = FW'(WINDOW_DEPTH);
		end else begin
			len_eff = FW'(window_len_q);
		end
	end

	assign fill_inc = {1'b0, fill_q} + 1'b1;
	assign fill_new = (fill_inc > {1'b0, len_eff}) ? len_eff : fill_inc[FW-1:0];
	assign wp_dec = (wp_q == '0) ? AW'(WINDOW_DEPTH - 1) : wp_q - 1'b1;
	assign rd_dec = (rd_ptr_q == '0) ? AW'(WINDOW_DEPTH - 1) : rd_ptr_q - 1'b1;
	assign wp_inc = (32'(wp_q) + 32'd1 == 32'(WINDOW_DEPTH)) ? '0 : wp_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_d1_q <= '0;
			lvl_d2_q <= '0;
			rsp_d1_q <= '0;
			rsp_d2_q <= '0;
			wp_q <= '0;
			fill_q <= '0;
			cnt_q <= '0;
			rdv_q <= 1'b0;
		end else begin
			rdv_q <= cmd.scan_rd;
			if (cmd.update) begin
				if (op_q) begin
					rsp_d1_q <= d1_new;
					rsp_d2_q <= d2_new;
				end else begin
					lvl_d1_q <= d1_new;
					lvl_d2_q <= d2_new;
				end
			end
			if (cmd.win_write) begin
				wp_q <= wp_inc;
				fill_q <= fill_new;
				cnt_q <= fill_new - 1'b1;
			end else if (cmd.scan_rd) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	bqpp_ram #(
		.WIDTH(32),
		.DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk     (clk),
		.wr_en   (cmd.win_write),
		.wr_addr (wp_q),
		.wr_data (y_q),
		.rd_en   (cmd.scan_rd),
		.rd_addr (rd_ptr_q),
		.rd_data (ram_rdata)
	);

	assign rd_val = ram_rdata;

	always_ff @(posedge clk) begin
		if (cmd.win_write) begin
			rd_ptr_q <= wp_dec;
			mn_q <= y_q;
			mx_q <= y_q;
		end else begin
			if (cmd.scan_rd) begin
				rd_ptr_q <= rd_dec;
			end
			if (rdv_q) begin
				if (rd_val < mn_q) begin
					mn_q <= rd_val;
				end
				if (rd_val > mx_q) begin
					mx_q <= rd_val;
				end
			end
		end
	end

	assign spread = {mx_q[31], mx_q} - {mn_q[31], mn_q};
	assign peak_sel = op_q ? spread[31:0] : last_spread_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_spread_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_out) begin
				last_spread_q <= peak_sel;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_channel_q <= op_q;
			out_filt_q <= y_q;
			out_peak_q <= peak_sel;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {out_peak_q, out_filt_q};
	assign m_tuser = out_channel_q;

	assign stat.resp = op_q;
	assign stat.cnt_zero = (cnt_q == '0);
	assign stat.cnt_one = (cnt_q == FW'(1));
	assign stat.out_free = !out_valid_q || m_tready;

endmodule

// ===== rtl/biquad_lowpass_window_peak_to_peak_core.sv =====
// Dual-channel skin-conductance lowpass with a peak-to-peak window.
// Input stream: s_tuser selects the channel (0 level, 1 response), s_tdata
// carries the raw Q8.24 sample. Every input item yields one output item on
// the m_ stream: the channel, the saturated filtered value and the window's
// max minus min (on level items, the last response spread is repeated).
// The block works on one item at a time. A level item steps through MUL_B,
// RND_P, SUM_Y, MUL_A1, MUL_A2, RND_Q2, UPDATE and FIN; a response item also
// writes the window and scans the entries held after the new value is written
// (up to the effective window length). The next item can be accepted once the
// result is in the output register. One shared 32x32 multiplier is used three
// times per item, and the scan reads one entry of the window RAM per cycle.
// s_tready is high only while the block is idle; the next item is taken
// while the previous result still sits in the output register.
// If the receiver stalls, the block finishes the next item and then holds
// it until the output register frees up.
// Reset clears the filter delays, the window fill count and the last spread,
// and loads the default coefficients and window length. The window RAM
// needs no clearing. Configuration must be written only while no item is in flight.
module biquad_lowpass_window_peak_to_peak_core import bqpp_pkg::*; #(
	parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_wr_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [31:0]            s_tdata,   // [31:0] sample_value
	input  logic [0:0]             s_tuser,   // [0] op
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [63:0]            m_tdata,   // [31:0] filtered_value, [63:32] peak_to_peak
	output logic [0:0]             m_tuser    // [0] channel
);

	cmd_t  cmd;
	stat_t stat;

	bqpp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bqpp_dp #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule

// ===== tb/biquad_lowpass_window_peak_to_peak_core_test.sv =====
`timescale 1ns / 1ps

module biquad_lowpass_window_peak_to_peak_core_test;
	import bqpp_pkg::*;

	localparam int DEPTH = WINDOW_DEPTH_DEF;
	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
	localparam logic [31:0] S32_MAX = 32'h7fff_ffff;
	localparam logic [31:0] S32_MIN = 32'h8000_0000;
	localparam longint Y_HI = 64'sd2147483647;
	localparam longint Y_LO = -64'sd2147483648;
	localparam longint D_HI = 64'sd140737488355327;
	localparam longint D_LO = -64'sd140737488355328;
	localparam logic CH_LEVEL = 1'b0;
	localparam logic CH_RESP = 1'b1;
	localparam int SINK_HOLD_CYCLES = 400;
	localparam int IDLE_LIMIT = 4000;
	localparam int END_SETTLE = 200;
	localparam int REPORT_MAX = 10;
	localparam int EXPECT_AW = 10;
	localparam int EXPECT_SLOTS = 1 << EXPECT_AW;

	typedef struct packed {
		logic channel;
		logic [31:0] filtered;
		logic [31:0] spread;
	} p2p_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [31:0] s_tdata = '0;
	logic [0:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic [0:0] m_tuser;

	biquad_lowpass_window_peak_to_peak_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #5 clk = ~clk;

	logic signed [31:0] lvl_gain, lvl_fb1, lvl_fb2;
	logic signed [31:0] rsp_gain, rsp_fb1, rsp_fb2;
	logic [7:0] win_len_reg;
	logic signed [47:0] lvl_d1, lvl_d2, rsp_d1, rsp_d2;
	logic signed [31:0] win_hist [DEPTH];
	logic [PTR_W-1:0] win_wr_ptr;
	logic [PTR_W:0] win_fill;
	logic [31:0] held_spread;

	p2p_result_t expected_items [EXPECT_SLOTS];
	int expected_count = 0;
	int checked_count = 0;
	p2p_result_t oldest_expected;
	int mismatch_count = 0;
	int idle_cycles = 0;
	bit source_gaps_on = 1'b1;
	bit sink_stalls_on = 1'b1;
	bit hold_receiver = 1'b0;

	function automatic longint round_q29(input longint v);
		return (v + 64'sd268435456) >>> 29;
	endfunction

	function automatic longint limit_range(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	task automatic run_lowpass(inout logic signed [47:0] d1, inout logic signed [47:0] d2,
			input logic signed [31:0] x, input logic signed [31:0] b0,
			input logic signed [31:0] a1, input logic signed [31:0] a2,
			output logic signed [31:0] y);
		longint p0, yl, q1, q2;
		p0 = round_q29(longint'(x) * longint'(b0));
		yl = limit_range(p0 + longint'(d1), Y_LO, Y_HI);
		q1 = round_q29(yl * longint'(a1));
		q2 = round_q29(yl * longint'(a2));
		d1 = 48'(limit_range(2 * p0 - q1 + longint'(d2), D_LO, D_HI));
		d2 = 48'(limit_range(p0 - q2, D_LO, D_HI));
		y = 32'(yl);
	endtask

	task automatic reset_predictor();
		lvl_gain = LEVEL_GAIN_RST;
		lvl_fb1 = LEVEL_FB1_RST;
		lvl_fb2 = LEVEL_FB2_RST;
		rsp_gain = RESP_GAIN_RST;
		rsp_fb1 = RESP_FB1_RST;
		rsp_fb2 = RESP_FB2_RST;
		win_len_reg = WINDOW_LEN_RST;
		lvl_d1 = '0;
		lvl_d2 = '0;
		rsp_d1 = '0;
		rsp_d2 = '0;
		win_wr_ptr = '0;
		win_fill = '0;
		held_spread = '0;
	endtask

	task automatic predict_result(input logic op, input logic signed [31:0] x,
			output p2p_result_t res);
		logic signed [31:0] y, v, mn, mx;
		logic [PTR_W-1:0] idx;
		int eff_len;
		if (op == CH_LEVEL) begin
			run_lowpass(lvl_d1, lvl_d2, x, lvl_gain, lvl_fb1, lvl_fb2, y);
		end else begin
			eff_len = win_len_reg;
			if (eff_len == 0) begin
				eff_len = 1;
			end
			if (eff_len > DEPTH) begin
				eff_len = DEPTH;
			end
			run_lowpass(rsp_d1, rsp_d2, x, rsp_gain, rsp_fb1, rsp_fb2, y);
			win_hist[win_wr_ptr] = y;
			idx = win_wr_ptr;
			win_wr_ptr = win_wr_ptr + 1'b1;
			win_fill = win_fill + 1'b1;
			if (win_fill > eff_len) begin
				win_fill = (PTR_W + 1)'(eff_len);
			end
			mn = y;
			mx = y;
			for (int k = 0; k < win_fill; k++) begin
				v = win_hist[idx];
				if (v < mn) begin
					mn = v;
				end
				if (v > mx) begin
					mx = v;
				end
				idx = idx - 1'b1;
			end
			held_spread = 32'(longint'(mx) - longint'(mn));
		end
		res.channel = op;
		res.filtered = y;
		res.spread = held_spread;
	endtask

	function automatic int next_gap(input bit allow, input int shortest);
		int r;
		r = $urandom_range(0, 99);
		if (!allow || r < 60) begin
			return shortest;
		end else if (r < 92) begin
			return $urandom_range(1, 4);
		end
		return $urandom_range(10, 50);
	endfunction

	function automatic logic [31:0] pick_sample();
		logic [31:0] r;
		int sel;
		r = $urandom;
		sel = $urandom_range(0, 9);
		if (sel == 0) begin
			return S32_MIN;
		end else if (sel == 1) begin
			return S32_MAX;
		end else if (sel < 5) begin
			return r;
		end
		return {{6{r[25]}}, r[25:0]};
	endfunction

	function automatic logic [31:0] pick_coeff(input logic [31:0] dflt);
		logic [31:0] r;
		int sel;
		r = $urandom;
		sel = $urandom_range(0, 19);
		if (sel < 8) begin
			return dflt;
		end else if (sel < 12) begin
			return {{3{r[28]}}, r[28:0]};
		end else if (sel < 17) begin
			return r;
		end else if (sel == 17) begin
			return S32_MIN;
		end else if (sel == 18) begin
			return S32_MAX;
		end
		return '0;
	endfunction

	function automatic logic [7:0] pick_window_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			return 8'd0;
		end else if (r < 30) begin
			return 8'($urandom_range(129, 255));
		end else if (r < 40) begin
			return 8'(DEPTH);
		end else if (r < 50) begin
			return 8'd1;
		end else if (r < 70) begin
			return 8'($urandom_range(2, 10));
		end
		return 8'($urandom_range(1, 128));
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_LEVEL_GAIN: lvl_gain = value;
			REG_LEVEL_FB1: lvl_fb1 = value;
			REG_LEVEL_FB2: lvl_fb2 = value;
			REG_RESP_GAIN: rsp_gain = value;
			REG_RESP_FB1: rsp_fb1 = value;
			REG_RESP_FB2: rsp_fb2 = value;
			REG_WINDOW_LEN: win_len_reg = value[7:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic load_settings(input logic [31:0] lg, input logic [31:0] lf1,
			input logic [31:0] lf2, input logic [31:0] rg, input logic [31:0] rf1,
			input logic [31:0] rf2, input logic [31:0] wl);
		write_reg(REG_LEVEL_GAIN, lg);
		write_reg(REG_LEVEL_FB1, lf1);
		write_reg(REG_LEVEL_FB2, lf2);
		write_reg(REG_RESP_GAIN, rg);
		write_reg(REG_RESP_FB1, rf1);
		write_reg(REG_RESP_FB2, rf2);
		write_reg(REG_WINDOW_LEN, wl);
	endtask

	task automatic send_sample(input logic op, input logic [31:0] value);
		p2p_result_t res;
		int gap;
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= value;
		do @(posedge clk); while (!s_tready);
		predict_result(op, value, res);
		expected_items[expected_count[EXPECT_AW-1:0]] = res;
		expected_count++;
		gap = next_gap(source_gaps_on, 0);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic finish_outstanding();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (expected_count != checked_count);
		repeat (2) @(posedge clk);
	endtask

	task automatic run_traffic(input int count, input int resp_pct);
		for (int i = 0; i < count; i++) begin
			send_sample($urandom_range(0, 99) < resp_pct ? CH_RESP : CH_LEVEL, pick_sample());
			if ($urandom_range(0, 99) < 2) begin
				finish_outstanding();
			end
		end
		finish_outstanding();
	endtask

	task automatic test_defaults_directed();
		send_sample(CH_LEVEL, 32'h0);
		send_sample(CH_LEVEL, S32_MAX);
		send_sample(CH_LEVEL, S32_MIN);
		send_sample(CH_LEVEL, S32_MIN);
		send_sample(CH_LEVEL, 32'h1);
		send_sample(CH_RESP, S32_MAX);
		send_sample(CH_RESP, S32_MIN);
		send_sample(CH_RESP, 32'h0);
		send_sample(CH_RESP, 32'hffff_ffff);
		send_sample(CH_RESP, 32'h0100_0000);
		send_sample(CH_LEVEL, 32'h0000_1234);
		finish_outstanding();
	endtask

	task automatic test_unmapped_register();
		write_reg(REG_UNMAPPED, 32'hffff_ffff);
		repeat (2) @(posedge clk);
		send_sample(CH_LEVEL, 32'h0200_0000);
		send_sample(CH_RESP, 32'hfe00_0000);
		finish_outstanding();
	endtask

	task automatic test_window_lengths();
		write_reg(REG_WINDOW_LEN, 32'd0);
		send_sample(CH_RESP, S32_MAX);
		send_sample(CH_RESP, S32_MIN);
		finish_outstanding();
		write_reg(REG_WINDOW_LEN, 32'd255);
		send_sample(CH_RESP, 32'h0300_0000);
		finish_outstanding();
		write_reg(REG_WINDOW_LEN, DEPTH);
		send_sample(CH_RESP, S32_MAX);
		send_sample(CH_RESP, S32_MIN);
		send_sample(CH_RESP, S32_MAX);
		finish_outstanding();
		write_reg(REG_WINDOW_LEN, 32'd2);
		send_sample(CH_RESP, 32'h0);
		finish_outstanding();
		write_reg(REG_WINDOW_LEN, DEPTH);
		send_sample(CH_RESP, S32_MIN);
		send_sample(CH_LEVEL, S32_MAX);
		finish_outstanding();
	endtask

	task automatic test_output_backpressure();
		source_gaps_on = 1'b0;
		hold_receiver = 1'b1;
		for (int i = 0; i < 12; i++) begin
			send_sample(i % 3 == 0 ? CH_LEVEL : CH_RESP, pick_sample());
		end
		source_gaps_on = 1'b1;
		finish_outstanding();
	endtask

	task automatic test_coefficient_extremes();
		load_settings(S32_MAX, S32_MIN, S32_MIN, S32_MAX, S32_MIN, S32_MIN, 32'd255);
		run_traffic(30, 50);
		load_settings(S32_MIN, S32_MAX, S32_MAX, S32_MIN, S32_MAX, S32_MAX, 32'd1);
		run_traffic(30, 50);
		load_settings(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'd0);
		run_traffic(30, 50);
	endtask

	task automatic test_random_settings();
		load_settings(LEVEL_GAIN_RST, LEVEL_FB1_RST, LEVEL_FB2_RST, RESP_GAIN_RST,
			RESP_FB1_RST, RESP_FB2_RST, DEPTH);
		run_traffic(160, 85);
		write_reg(REG_WINDOW_LEN, 32'd4);
		run_traffic(40, 70);
		for (int p = 0; p < 6; p++) begin
			load_settings(pick_coeff(LEVEL_GAIN_RST), pick_coeff(LEVEL_FB1_RST),
				pick_coeff(LEVEL_FB2_RST), pick_coeff(RESP_GAIN_RST),
				pick_coeff(RESP_FB1_RST), pick_coeff(RESP_FB2_RST),
				{8'($urandom), 8'($urandom), 8'($urandom), pick_window_len()});
			source_gaps_on = (p != 2);
			sink_stalls_on = (p != 2);
			run_traffic(42, $urandom_range(40, 90));
		end
		source_gaps_on = 1'b1;
		sink_stalls_on = 1'b1;
	endtask

	initial begin
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_receiver) begin
				hold_receiver = 1'b0;
				m_tready <= 1'b0;
				repeat (SINK_HOLD_CYCLES) @(posedge clk);
			end else if (!sink_stalls_on) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				m_tready <= 1'b0;
				repeat (next_gap(1'b1, 1)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_count == checked_count) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_MAX) begin
					$display("unexpected item: channel %0d filtered %h spread %h",
						m_tuser[0], m_tdata[31:0], m_tdata[63:32]);
				end
			end else begin
				oldest_expected = expected_items[checked_count[EXPECT_AW-1:0]];
				checked_count++;
				if (m_tuser[0] !== oldest_expected.channel
						|| m_tdata[31:0] !== oldest_expected.filtered
						|| m_tdata[63:32] !== oldest_expected.spread) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_MAX) begin
						$display("mismatch: expected channel %0d filtered %h spread %h",
							oldest_expected.channel, oldest_expected.filtered,
							oldest_expected.spread);
						$display("          got      channel %0d filtered %h spread %h",
							m_tuser[0], m_tdata[31:0], m_tdata[63:32]);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("biquad_lowpass_window_peak_to_peak_core verification failed");
			$finish;
		end
	end

	initial begin
		reset_predictor();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_defaults_directed();
		test_unmapped_register();
		test_window_lengths();
		test_output_backpressure();
		test_coefficient_extremes();
		test_random_settings();
		finish_outstanding();
		repeat (END_SETTLE) @(posedge clk);
		if (mismatch_count == 0 && expected_count == checked_count) begin
			$display("biquad_lowpass_window_peak_to_peak_core verification clean");
		end else begin
			$display("biquad_lowpass_window_peak_to_peak_core verification failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bqpp_pkg.sv
rtl/bqpp_ram.sv
rtl/bqpp_ctrl.sv
rtl/bqpp_dp.sv
rtl/biquad_lowpass_window_peak_to_peak_core.sv
tb/biquad_lowpass_window_peak_to_peak_core_test.sv
